/* design/periodic_box_wrap_2d_defines.svh */
// Assertion macros for the periodic box block
`ifndef PERIODIC_BOX_WRAP_2D_DEFINES_SVH
`define PERIODIC_BOX_WRAP_2D_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define PBW_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PBW_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PBW_ASSERT(label, clk, rst_n, prop, msg)
`define PBW_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

/* design/pbw_pkg.sv */
package pbw_pkg;
	localparam int unsigned CFG_ADDR_BITS = 4;
	// fraction position of the Q-format codes; arithmetic works on raw codes
	localparam int unsigned FRAC_BITS = 16;
	typedef enum logic [1:0] {
		FUNC_INSIDE = 2'd0,
		FUNC_WRAP   = 2'd1,
		FUNC_FOLD   = 2'd2,
		FUNC_PASS   = 2'd3
	} func_t;
	typedef enum logic [1:0] {
		REG_CORNER_A_X = 2'd0,
		REG_CORNER_A_Y = 2'd1,
		REG_CORNER_B_X = 2'd2,
		REG_CORNER_B_Y = 2'd3
	} reg_idx_t;
endpackage

/* design/pbw_if.sv */
interface pbw_in_if #(parameter int COORD_BITS = 32) (input logic clk);
	logic                         valid;
	logic                         ready;
	logic [1:0]                   func;
	logic signed [COORD_BITS-1:0] coord_x;
	logic signed [COORD_BITS-1:0] coord_y;
	logic [COORD_BITS-2:0]        margin;
	modport source (output valid, func, coord_x, coord_y, margin, input ready);
	modport sink (input valid, func, coord_x, coord_y, margin, output ready);
endinterface

interface pbw_out_if #(parameter int COORD_BITS = 32) (input logic clk);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] out_x;
	logic signed [COORD_BITS-1:0] out_y;
	logic                         inside_res;
	modport source (output valid, out_x, out_y, inside_res, input ready);
	modport sink (input valid, out_x, out_y, inside_res, output ready);
endinterface

/* design/pbw_cell.sv */
// One step of restoring reduction: subtract range<<SHIFT from the offset if it fits.
// Wrap offsets are kept as distances from the lower bound (biased, unsigned).
module pbw_cell import pbw_pkg::*; #(
	parameter int W     = 32,
	parameter int SHIFT = 0
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] rng_i,
	input  logic [W-1:0] rem_i,
	output logic [W-1:0] rng_o,
	output logic [W-1:0] rem_o
);
	logic [W+SHIFT:0] sub;
	logic [W-1:0]     rem_n;
	always_comb begin
		sub   = {{(SHIFT+1){1'b0}}, rng_i} << SHIFT;
		rem_n = rem_i;
		if (rng_i != '0 && {{(SHIFT+1){1'b0}}, rem_i} >= sub)
			rem_n = rem_i - sub[W-1:0];
	end
	always_ff @(posedge clk) begin
		if (en) begin
			rng_o <= rng_i;
			rem_o <= rem_n;
		end
	end
endmodule

/* design/pbw_axis.sv */
// One axis: a chain of W reduction cells, with side data riding alongside.
module pbw_axis import pbw_pkg::*; #(
	parameter int W = 32
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] corner_a,
	input  logic [W-1:0] corner_b,
	input  logic [1:0]   func,
	input  logic [W-1:0] coord,
	input  logic [W-2:0] margin,
	output logic [W-1:0] res,
	output logic         ok
);
	localparam logic [W-1:0] SGN = {1'b1, {(W-1){1'b0}}};
	logic [W-1:0] ua, ub, lo, hi, rng, u, half, fold, off;
	logic         below, ins;
	logic [W-1:0] rng_c [W+1];
	logic [W-1:0] rem_c [W+1];
	logic [W-1:0] lo_p  [W+1];
	logic [W-1:0] by_p  [W+1];
	logic         neg_p [W+1];
	logic         wrp_p [W+1];
	always_comb begin
		ua = corner_a ^ SGN;
		ub = corner_b ^ SGN;
		lo = (ua < ub) ? ua : ub;
		hi = (ua < ub) ? ub : ua;
		rng = hi - lo;
		u = coord ^ SGN;
		half = rng >> 1;
		below = u < lo;
		off = below ? lo - u : u - lo;
		ins = 1'b1;
		if (rng != '0) begin
			if (below && (lo - u) > {1'b0, margin}) ins = 1'b0;
			if (u > hi && (u - hi) > {1'b0, margin}) ins = 1'b0;
		end
		fold = coord;
		if (rng != '0) begin
			if (!coord[W-1]) begin
				if (coord >= rng - half) fold = coord - rng;
			end else if (((coord == SGN) ? SGN : -coord) > half) begin
				fold = coord + rng;
			end
		end
	end
	assign rng_c[0] = rng;
	assign rem_c[0] = off;
	assign lo_p[0]  = lo;
	assign neg_p[0] = below;
	assign wrp_p[0] = (func == FUNC_WRAP) && (rng != '0);
	assign by_p[0]  = (func == FUNC_FOLD) ? fold : coord;
	for (genvar i = 0; i < W; i++) begin : g_cell
		pbw_cell #(.W(W), .SHIFT(W-1-i)) u_cell (
			.clk(clk), .en(en),
			.rng_i(rng_c[i]), .rem_i(rem_c[i]),
			.rng_o(rng_c[i+1]), .rem_o(rem_c[i+1])
		);
		always_ff @(posedge clk) begin
			if (en) begin
				lo_p[i+1]  <= lo_p[i];
				by_p[i+1]  <= by_p[i];
				neg_p[i+1] <= neg_p[i];
				wrp_p[i+1] <= wrp_p[i];
			end
		end
	end
	assign ok = ins;
	always_comb begin
		res = by_p[W];
		if (wrp_p[W]) begin
			if (neg_p[W] && rem_c[W] != '0)
				res = (lo_p[W] + rng_c[W] - rem_c[W]) ^ SGN;
			else
				res = (lo_p[W] + rem_c[W]) ^ SGN;
		end
	end
endmodule

/* design/periodic_box_wrap_2d.sv */
// Each accepted word passes the reduction cells of both axes and then the output register.
// Throughput: one word per cycle unless the output stalls; the path is a chain of COORD_BITS reduction
// cells per axis, one quotient bit resolved in each cell.
// The pipeline stalls as a whole when the output register is full and not taken.
// Reset (arst_n low, asynchronous) clears all valid bits and the corners to 0.
`include "periodic_box_wrap_2d_defines.svh"
module periodic_box_wrap_2d import pbw_pkg::*; #(
	parameter int COORD_BITS = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	pbw_in_if.sink                   in_if,
	pbw_out_if.source                out_if,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [CFG_ADDR_BITS-1:0] paddr,
	input  logic [31:0]              pwdata,
	output logic [31:0]              prdata,
	output logic                     pready
);
	localparam int L = COORD_BITS + 1;
	logic [COORD_BITS-1:0] ca_x_q, ca_y_q, cb_x_q, cb_y_q;
	logic [L-1:0]          vld_q;
	logic [L-2:0]          ins_q;
	logic                  en, wr;
	logic [COORD_BITS-1:0] wdat;
	logic [COORD_BITS-1:0] rx, ry;
	logic                  okx, oky;
	reg_idx_t              ridx;

	assign pready = 1'b1;
	assign ridx   = reg_idx_t'(paddr[3:2]);
	assign wr     = psel && penable && pwrite && pready;
	assign wdat   = COORD_BITS'({{32{pwdata[31]}}, pwdata});
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ca_x_q <= '0; ca_y_q <= '0; cb_x_q <= '0; cb_y_q <= '0;
		end else if (wr) begin
			unique case (ridx)
				REG_CORNER_A_X: ca_x_q <= wdat;
				REG_CORNER_A_Y: ca_y_q <= wdat;
				REG_CORNER_B_X: cb_x_q <= wdat;
				REG_CORNER_B_Y: cb_y_q <= wdat;
				default: ;
			endcase
		end
	end
	always_comb begin
		unique case (ridx)
			REG_CORNER_A_X: prdata = 32'(ca_x_q);
			REG_CORNER_A_Y: prdata = 32'(ca_y_q);
			REG_CORNER_B_X: prdata = 32'(cb_x_q);
			REG_CORNER_B_Y: prdata = 32'(cb_y_q);
			default:        prdata = '0;
		endcase
	end

	assign en = !vld_q[L-1] || out_if.ready;
	assign in_if.ready = en;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[L-2:0], in_if.valid};
		end
	end
	always_ff @(posedge clk) begin
		if (en) ins_q <= {ins_q[L-3:0],
			(in_if.func == FUNC_INSIDE) && okx && oky};
	end

	pbw_axis #(.W(COORD_BITS)) u_ax (
		.clk(clk), .en(en), .corner_a(ca_x_q), .corner_b(cb_x_q),
		.func(in_if.func), .coord(in_if.coord_x), .margin(in_if.margin),
		.res(rx), .ok(okx)
	);
	pbw_axis #(.W(COORD_BITS)) u_ay (
		.clk(clk), .en(en), .corner_a(ca_y_q), .corner_b(cb_y_q),
		.func(in_if.func), .coord(in_if.coord_y), .margin(in_if.margin),
		.res(ry), .ok(oky)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			out_if.out_x      <= rx;
			out_if.out_y      <= ry;
			out_if.inside_res <= ins_q[L-2];
		end
	end
	assign out_if.valid = vld_q[L-1];

	`PBW_ASSERT(a_stall_hold, clk, arst_n, out_if.valid && !out_if.ready |=> out_if.valid, "valid dropped under stall")
	`PBW_ASSERT(a_ready_rule, clk, arst_n, in_if.ready == (!out_if.valid || out_if.ready), "ready mismatch")
	`PBW_ASSERT(a_vld_in, clk, arst_n, en |=> vld_q[0] == $past(in_if.valid), "input valid not captured")
	`PBW_ASSERT_ALWAYS(a_pready, clk, pready, "pready low")
endmodule

/* tb/tb_periodic_box_wrap_2d.sv */
module tb_periodic_box_wrap_2d;
	import pbw_pkg::*;

	localparam int CB = 32;
	localparam int LIMIT = 400000;

	logic clk = 0;
	logic arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [CFG_ADDR_BITS-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	pbw_in_if #(CB) in_if (clk);
	pbw_out_if #(CB) out_if (clk);

	periodic_box_wrap_2d #(.COORD_BITS(CB)) DUT (
		.clk(clk), .arst_n(arst_n), .in_if(in_if.sink), .out_if(out_if.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	typedef struct packed {
		logic [CB-1:0] x;
		logic [CB-1:0] y;
		logic          ins;
	} box_res_t;

	box_res_t pending_q[$];
	logic [CB-1:0] corners[4];
	int errors = 0;
	int cycles = 0;
	int sent = 0, got = 0;
	int send_idle = 0, recv_idle = 0;
	bit hold_off = 0;

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("timeout at %0t", $time);
			$display("FAILED: results differ");
			$finish;
		end
	end

	// bounds kept in biased (sign-flipped) form, 33-bit for unlimited margins
	function automatic void axis_bounds(input logic [CB-1:0] a, input logic [CB-1:0] b,
			output logic [CB:0] lo, output logic [CB:0] hi, output logic [CB:0] rng);
		logic [CB:0] ua, ub;
		ua = {1'b0, a ^ (1 << (CB-1))};
		ub = {1'b0, b ^ (1 << (CB-1))};
		lo = (ua < ub) ? ua : ub;
		hi = (ua < ub) ? ub : ua;
		rng = hi - lo;
	endfunction

	function automatic logic axis_in(input logic [CB-1:0] a, input logic [CB-1:0] b,
			input logic [CB-1:0] p, input logic [CB-2:0] m);
		logic [CB:0] lo, hi, rng, u;
		axis_bounds(a, b, lo, hi, rng);
		u = {1'b0, p ^ (1 << (CB-1))};
		if (rng == 0) return 1;
		if (u < lo && (lo - u) > m) return 0;
		if (u > hi && (u - hi) > m) return 0;
		return 1;
	endfunction

	function automatic logic [CB-1:0] axis_wrap(input logic [CB-1:0] a,
			input logic [CB-1:0] b, input logic [CB-1:0] p);
		logic [CB:0] lo, hi, rng, u, md, s;
		axis_bounds(a, b, lo, hi, rng);
		u = {1'b0, p ^ (1 << (CB-1))};
		if (rng == 0) return p;
		if (u >= lo) md = (u - lo) % rng;
		else begin
			md = (lo - u) % rng;
			md = (md != 0) ? rng - md : 0;
		end
		s = lo + md;
		return s[CB-1:0] ^ (1 << (CB-1));
	endfunction

	function automatic logic [CB-1:0] axis_fold(input logic [CB-1:0] a,
			input logic [CB-1:0] b, input logic [CB-1:0] d);
		logic [CB:0] lo, hi, rng, half, mag;
		axis_bounds(a, b, lo, hi, rng);
		half = rng >> 1;
		if (rng == 0) return d;
		if (!d[CB-1]) begin
			if ({1'b0, d} >= rng - half) return d - rng[CB-1:0];
		end else begin
			mag = {1'b0, -d};
			if (mag == 0) mag = 1 << (CB-1);
			if (mag > half) return d + rng[CB-1:0];
		end
		return d;
	endfunction

	function automatic box_res_t predict_box(input logic [1:0] f, input logic [CB-1:0] px,
			input logic [CB-1:0] py, input logic [CB-2:0] m);
		box_res_t r;
		r.x = px;
		r.y = py;
		r.ins = 0;
		case (func_t'(f))
			FUNC_INSIDE: r.ins = axis_in(corners[REG_CORNER_A_X], corners[REG_CORNER_B_X], px, m)
				&& axis_in(corners[REG_CORNER_A_Y], corners[REG_CORNER_B_Y], py, m);
			FUNC_WRAP: begin
				r.x = axis_wrap(corners[REG_CORNER_A_X], corners[REG_CORNER_B_X], px);
				r.y = axis_wrap(corners[REG_CORNER_A_Y], corners[REG_CORNER_B_Y], py);
			end
			FUNC_FOLD: begin
				r.x = axis_fold(corners[REG_CORNER_A_X], corners[REG_CORNER_B_X], px);
				r.y = axis_fold(corners[REG_CORNER_A_Y], corners[REG_CORNER_B_Y], py);
			end
			default: ;
		endcase
		return r;
	endfunction

	// receiver ready
	initial begin
		out_if.ready = 0;
		forever begin
			@(negedge clk);
			out_if.ready <= !hold_off && ($urandom_range(99) >= recv_idle);
		end
	end

	// result checker
	always @(posedge clk) begin
		box_res_t e;
		if (arst_n && out_if.valid && out_if.ready) begin
			got++;
			if (pending_q.size() == 0) begin
				$display("%0t unexpected word x=%h y=%h ins=%b", $time,
					out_if.out_x, out_if.out_y, out_if.inside_res);
				errors++;
			end else begin
				e = pending_q.pop_front();
				if (e.x !== out_if.out_x || e.y !== out_if.out_y || e.ins !== out_if.inside_res) begin
					$display("%0t mismatch exp x=%h y=%h ins=%b act x=%h y=%h ins=%b", $time,
						e.x, e.y, e.ins, out_if.out_x, out_if.out_y, out_if.inside_res);
					errors++;
				end
			end
		end
	end

	task automatic send_word(input func_t f, input logic [CB-1:0] px,
			input logic [CB-1:0] py, input logic [CB-2:0] m);
		while ($urandom_range(99) < send_idle) begin
			in_if.valid <= 0;
			@(negedge clk);
		end
		in_if.valid <= 1;
		in_if.func <= f;
		in_if.coord_x <= px;
		in_if.coord_y <= py;
		in_if.margin <= m;
		pending_q.push_back(predict_box(f, px, py, m));
		sent++;
		@(posedge clk);
		while (!in_if.ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic end_burst();
		in_if.valid <= 0;
		while (pending_q.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic write_corner(input reg_idx_t idx, input logic [31:0] v);
		psel <= 1;
		pwrite <= 1;
		penable <= 0;
		paddr <= CFG_ADDR_BITS'(4 * idx);
		pwdata <= v;
		@(negedge clk);
		penable <= 1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		corners[idx] = v;
		@(negedge clk);
	endtask

	task automatic set_box(input logic [31:0] ax, input logic [31:0] ay,
			input logic [31:0] bx, input logic [31:0] by);
		write_corner(REG_CORNER_A_X, ax);
		write_corner(REG_CORNER_A_Y, ay);
		write_corner(REG_CORNER_B_X, bx);
		write_corner(REG_CORNER_B_Y, by);
	endtask

	function automatic logic [CB-1:0] rand_coord();
		case ($urandom_range(5))
			0: return 32'h8000_0000 + $urandom_range(3);
			1: return 32'h7fff_ffff - $urandom_range(3);
			2: return $urandom_range(8) - 4;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [CB-1:0] near_box(input logic [CB-1:0] a, input logic [CB-1:0] b);
		logic [CB-1:0] rng;
		rng = b - a;
		case ($urandom_range(4))
			0: return a + rng * $urandom_range(5) - $urandom_range(2) + 1;
			1: return a - rng * $urandom_range(4);
			2: return rng + $urandom_range(2) - 1;
			3: return -rng - $urandom_range(2) + 1;
			default: return a + $urandom_range(16) * (rng >> 2);
		endcase
	endfunction

	task automatic test_reset_box();
		// all axes off after reset
		send_word(FUNC_INSIDE, 32'h8000_0000, 32'h7fff_ffff, '0);
		send_word(FUNC_WRAP, 32'h1234_5678, 32'h8000_0000, '1);
		send_word(FUNC_FOLD, 32'h7fff_ffff, 32'hffff_ffff, '0);
		send_word(FUNC_PASS, 32'hdead_beef, 32'h0bad_f00d, '1);
		end_burst();
	endtask

	task automatic test_directed();
		set_box(32'h0005_0000, 32'h7fff_ffff, 32'hfffb_0000, 32'h8000_0000);
		send_word(FUNC_INSIDE, 32'h0005_0000, 32'h7fff_ffff, '0);
		send_word(FUNC_INSIDE, 32'h0005_0001, 32'h0, '0);
		send_word(FUNC_INSIDE, 32'h0005_0001, 32'h0, 31'd1);
		send_word(FUNC_INSIDE, 32'hfffa_ffff, 32'h0, 31'd1);
		send_word(FUNC_INSIDE, 32'h8000_0000, 32'h0, '1);
		send_word(FUNC_WRAP, 32'h0005_0000, 32'h7fff_ffff, '0);
		send_word(FUNC_WRAP, 32'hfff1_0000, 32'h8000_0000, '0);  // multiple below lower
		send_word(FUNC_WRAP, 32'h7fff_ffff, 32'h1, '0);
		send_word(FUNC_WRAP, 32'h8000_0000, 32'h0, '0);
		send_word(FUNC_FOLD, 32'h0005_0000, 32'h7fff_ffff, '0);
		send_word(FUNC_FOLD, 32'hfffb_0000, 32'h8000_0000, '0);
		send_word(FUNC_FOLD, 32'h0004_ffff, 32'h8000_0001, '0);
		send_word(FUNC_FOLD, 32'h7fff_ffff, 32'h0, '0);
		send_word(FUNC_FOLD, 32'h8000_0000, 32'h1, '0);
		send_word(FUNC_PASS, 32'h8000_0000, 32'h7fff_ffff, '1);
		end_burst();
		// one axis off, one unit range, full span
		set_box(32'h7fff_ffff, 32'h0001_0000, 32'h8000_0000, 32'h0001_0000);
		send_word(FUNC_INSIDE, 32'h0, 32'h8000_0000, '0);
		send_word(FUNC_WRAP, 32'h7fff_ffff, 32'hdead_beef, '0);
		send_word(FUNC_FOLD, 32'h7fff_fffe, 32'h8000_0000, '0);
		end_burst();
		set_box(32'h3, 32'h8000_0000, 32'h4, 32'h8000_0001);
		send_word(FUNC_WRAP, 32'h8000_0000, 32'h7fff_ffff, '0);
		send_word(FUNC_FOLD, 32'h1, 32'hffff_ffff, '0);
		end_burst();
	endtask

	task automatic test_random(input int n_words);
		logic [CB-1:0] a[4];
		for (int k = 0; k < n_words; k++) begin
			if (k % 50 == 0) begin
				end_burst();
				for (int i = 0; i < 4; i++) a[i] = ($urandom_range(3) == 0) ? rand_coord()
					: $signed($urandom) >>> $urandom_range(20);
				if ($urandom_range(7) == 0) a[2] = a[0];
				set_box(a[0], a[1], a[2], a[3]);
			end
			if ($urandom_range(4) == 0)
				send_word(func_t'($urandom_range(3)), rand_coord(), rand_coord(),
					31'($urandom_range(1) ? $urandom : $urandom_range(70000)));
			else
				send_word(func_t'($urandom_range(2)), near_box(a[0], a[2]), near_box(a[1], a[3]),
					31'($urandom_range(3) == 0 ? $urandom : $urandom_range(70000)));
		end
		end_burst();
	endtask

	task automatic test_backpressure();
		fork
			begin
				hold_off = 1;
				repeat (300) @(negedge clk);
				hold_off = 0;
			end
			for (int k = 0; k < 120; k++)
				send_word(func_t'($urandom_range(2)), $urandom, $urandom, 31'($urandom));
		join
		end_burst();
	endtask

	initial begin
		in_if.valid = 0;
		in_if.func = '0;
		in_if.coord_x = '0;
		in_if.coord_y = '0;
		in_if.margin = '0;
		for (int i = 0; i < 4; i++) corners[i] = '0;
		repeat (5) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		test_reset_box();
		test_directed();
		send_idle = 19; recv_idle = 65;
		test_random(370);
		send_idle = 65; recv_idle = 19;
		test_random(370);
		send_idle = 0; recv_idle = 0;
		test_random(370);
		test_backpressure();
		$display("Sent %0d words, checked %0d results over many box settings,", sent, got);
		$display("including disabled axes, edge corners, stalls and a long output hold-off.");
		if (errors == 0 && pending_q.size() == 0) $display("PASSED: all results match");
		else $display("FAILED: results differ");
		$finish;
	end
endmodule

/* filelist.f */
+incdir+design
design/pbw_pkg.sv
design/pbw_if.sv
design/pbw_cell.sv
design/pbw_axis.sv
design/periodic_box_wrap_2d.sv
tb/tb_periodic_box_wrap_2d.sv
